[rtl/bitmap_slab_slot_allocator_macros.svh]
// Assertion macros for the slab slot allocator RTL
`ifndef BITMAP_SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLAB_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define BSSA_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define BSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bssa_pkg.sv]
// Types, constants and helper functions for the slab slot allocator
package bssa_pkg;

   localparam int PAGES    = 16;
   localparam int SLOTS    = 32;
   localparam int PAGE_W   = 4;
   localparam int PAGE_NUM = 1 << PAGE_W;
   localparam int POOL     = (PAGES < PAGE_NUM) ? PAGES : PAGE_NUM;
   localparam int SLOT_W   = 5;
   localparam int OFF_W    = 11;
   localparam int LEN_W    = 5;
   localparam int SIZE_W   = 7;
   localparam int SHIFT_W  = 3;
   localparam int STATUS_W = 2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PAGES = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INACTIVE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd3;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // The head of the page list is always page zero
   localparam logic [PAGE_W-1:0] HEAD_PAGE = '0;

   typedef struct packed {
      logic              operation;
      logic [PAGE_W-1:0] page;
      logic [OFF_W-1:0]  byte_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   out_page;
      logic [SLOT_W-1:0]   out_slot;
      logic [OFF_W-1:0]    out_offset;
      logic                page_taken;
      logic                page_released;
   } rsp_type;

   // Access to the slot mask memory
   typedef struct packed {
      logic              re;
      logic [PAGE_W-1:0] raddr;
      logic              we;
      logic [PAGE_W-1:0] waddr;
      logic [SLOTS-1:0]  wdata;
   } mask_port_type;

   // Access to the page list memory
   typedef struct packed {
      logic              re;
      logic [PAGE_W-1:0] raddr;
      logic              we;
      logic [PAGE_W-1:0] waddr;
      logic [PAGE_W-1:0] wdata;
   } list_port_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FREE_MASK,
      ST_FREE_LIST,
      ST_DONE
   } state_type;

   // ceil(log2(size)), sizes 0 and 1 give 0, clamped at 6
   function automatic logic [SHIFT_W-1:0] size_shift(input logic [SIZE_W-1:0] size);
      logic [SHIFT_W-1:0] s;
      if (size <= 7'd1) s = 3'd0;
      else if (size <= 7'd2) s = 3'd1;
      else if (size <= 7'd4) s = 3'd2;
      else if (size <= 7'd8) s = 3'd3;
      else if (size <= 7'd16) s = 3'd4;
      else if (size <= 7'd32) s = 3'd5;
      else s = 3'd6;
      return s;
   endfunction

   // Lowest clear bit; the top slot when bits below it are all set
   function automatic logic [SLOT_W-1:0] lowest_zero(input logic [SLOTS-1:0] m);
      logic [SLOT_W-1:0] r;
      r = SLOT_W'(SLOTS - 1);
      for (int i = SLOTS - 2; i >= 0; i--) begin
         if (!m[i]) r = SLOT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [OFF_W-1:0] slot_offset(input logic [SLOT_W-1:0] slot,
                                                     input logic [SHIFT_W-1:0] shift);
      return OFF_W'({{(OFF_W-SLOT_W){1'b0}}, slot} << shift);
   endfunction

endpackage

[rtl/bssa_ram.sv]
// Single-port-write, single-port-read RAM with per-entry valid bits and write forwarding
module bssa_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                    rd_data,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                    wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_q_ff;
   logic              rd_valid_ff;
   logic              fwd;

   // read of the entry being written returns the new data
   assign fwd = wr_en && rd_en && (wr_addr == rd_addr);

   // storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_q_ff <= fwd ? wr_data : mem_ff[rd_addr];
   end

   // valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_addr] <= 1'b1;
         if (rd_en) rd_valid_ff <= fwd || valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

[rtl/bssa_ctrl.sv]
// Allocator sequencer: list walk, append, free and page release over the two memories
`include "bitmap_slab_slot_allocator_macros.svh"

module bssa_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bssa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bssa_pkg::rsp_type                   rsp_data,
   input  logic [bssa_pkg::SHIFT_W-1:0]        shift,
   output bssa_pkg::mask_port_type             mask_port,
   input  logic [bssa_pkg::SLOTS-1:0]          mask_rdata,
   output bssa_pkg::list_port_type             list_port,
   input  logic [bssa_pkg::PAGE_W-1:0]         list_rdata
);
   import bssa_pkg::*;

   state_type           state_ff, state_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [LEN_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                lpg_vld_ff, lpg_vld_in;
   logic                mchk_vld_ff, mchk_vld_in;
   logic [PAGE_W-1:0]   mpg_ff, mpg_in;
   logic                found_ff, found_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [PAGE_NUM-1:0] active_ff, active_in;
   rsp_type             res_ff, res_in;
   logic                rsp_vld_ff, rsp_vld_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_fire;
   logic [OFF_W-1:0]    free_slot;
   logic                free_slot_big;
   logic                req_page_ok;
   logic                mask_free;
   logic                walk_end;
   logic                list_done;
   logic                append_ok;
   logic [PAGE_W-1:0]   free_page;
   logic [SLOT_W-1:0]   alloc_slot;
   logic                free_hit;
   logic [SLOTS-1:0]    cleared;
   logic                release_pg;
   logic [LEN_W-1:0]    shift_idx;
   logic                res_load;

   // shared decodes
   assign req_ready     = (state_ff == ST_IDLE);
   assign req_fire      = req_valid && req_ready;
   assign free_slot     = req_data.byte_offset >> shift;
   assign free_slot_big = |free_slot[OFF_W-1:SLOT_W];
   assign req_page_ok   = ({1'b0, req_data.page} < LEN_W'(POOL)) && active_ff[req_data.page];
   assign mask_free     = mchk_vld_ff && (mask_rdata != '1);
   assign walk_end      = !mask_free && !lpg_vld_ff && (rd_idx_ff >= len_ff);
   assign list_done     = !lpg_vld_ff && (rd_idx_ff >= len_ff);
   assign append_ok     = (len_ff < LEN_W'(POOL));
   assign alloc_slot    = lowest_zero(mask_rdata);
   assign free_hit      = mask_rdata[slot_ff];
   assign cleared       = mask_rdata & ~(SLOTS'(1) << slot_ff);
   assign release_pg    = (cleared == '0) && (page_ff != HEAD_PAGE);
   assign shift_idx     = rd_idx_ff - LEN_W'(2);
   assign res_load      = !rsp_vld_ff || rsp_ready;

   // lowest inactive page of the pool
   always_comb begin
      free_page = '0;
      for (int i = POOL - 1; i >= 0; i--) begin
         if (!active_ff[i]) free_page = PAGE_W'(i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == OP_ALLOC) state_in = ST_WALK;
               else if (!req_page_ok || free_slot_big) state_in = ST_DONE;
               else state_in = ST_FREE_MASK;
            end
         end
         ST_WALK: begin
            if (mask_free || walk_end) state_in = ST_DONE;
         end
         ST_FREE_MASK: begin
            if (free_hit && release_pg) state_in = ST_FREE_LIST;
            else state_in = ST_DONE;
         end
         ST_FREE_LIST: begin
            if (list_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, memory accesses and response
   always_comb begin
      page_in     = page_ff;
      slot_in     = slot_ff;
      rd_idx_in   = rd_idx_ff;
      lpg_vld_in  = lpg_vld_ff;
      mchk_vld_in = mchk_vld_ff;
      mpg_in      = mpg_ff;
      found_in    = found_ff;
      len_in      = len_ff;
      active_in   = active_ff;
      res_in      = res_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ready;
      mask_port   = '0;
      list_port   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               page_in     = req_data.page;
               slot_in     = free_slot[SLOT_W-1:0];
               rd_idx_in   = '0;
               lpg_vld_in  = 1'b0;
               mchk_vld_in = 1'b0;
               found_in    = 1'b0;
               res_in      = '0;
               res_in.out_page = req_data.page;
               if (req_data.operation == OP_FREE) begin
                  if (!req_page_ok) begin
                     res_in.status = STATUS_INACTIVE;
                  end else if (free_slot_big) begin
                     res_in.status = STATUS_NOT_HELD;
                  end else begin
                     mask_port.re    = 1'b1;
                     mask_port.raddr = req_data.page;
                  end
               end
            end
         end

         // list entry and mask read overlap, one entry a cycle
         ST_WALK: begin
            if (mask_free) begin
               mask_port.we    = 1'b1;
               mask_port.waddr = mpg_ff;
               mask_port.wdata = mask_rdata | (SLOTS'(1) << alloc_slot);
               res_in               = '0;
               res_in.status        = STATUS_OK;
               res_in.out_page      = mpg_ff;
               res_in.out_slot      = alloc_slot;
               res_in.out_offset    = slot_offset(alloc_slot, shift);
            end else if (walk_end) begin
               res_in = '0;
               if (append_ok) begin
                  active_in[free_page] = 1'b1;
                  list_port.we    = 1'b1;
                  list_port.waddr = len_ff[PAGE_W-1:0];
                  list_port.wdata = free_page;
                  mask_port.we    = 1'b1;
                  mask_port.waddr = free_page;
                  mask_port.wdata = SLOTS'(1);
                  len_in          = len_ff + LEN_W'(1);
                  res_in.status     = STATUS_OK;
                  res_in.out_page   = free_page;
                  res_in.page_taken = 1'b1;
               end else begin
                  res_in.status = STATUS_NO_PAGES;
               end
            end else begin
               mchk_vld_in = lpg_vld_ff;
               if (lpg_vld_ff) begin
                  mask_port.re    = 1'b1;
                  mask_port.raddr = list_rdata;
                  mpg_in          = list_rdata;
               end
               lpg_vld_in = (rd_idx_ff < len_ff);
               if (rd_idx_ff < len_ff) begin
                  list_port.re    = 1'b1;
                  list_port.raddr = rd_idx_ff[PAGE_W-1:0];
                  rd_idx_in       = rd_idx_ff + LEN_W'(1);
               end
            end
         end

         ST_FREE_MASK: begin
            res_in          = '0;
            res_in.out_page = page_ff;
            if (!free_hit) begin
               res_in.status = STATUS_NOT_HELD;
            end else begin
               mask_port.we    = 1'b1;
               mask_port.waddr = page_ff;
               mask_port.wdata = cleared;
               res_in.status        = STATUS_OK;
               res_in.out_slot      = slot_ff;
               res_in.out_offset    = slot_offset(slot_ff, shift);
               res_in.page_released = release_pg;
               if (release_pg) begin
                  active_in[page_ff] = 1'b0;
                  rd_idx_in  = LEN_W'(1);
                  lpg_vld_in = 1'b0;
                  found_in   = 1'b0;
               end
            end
         end

         // find the released page, then move later entries down by one
         ST_FREE_LIST: begin
            if (lpg_vld_ff) begin
               if (found_ff) begin
                  list_port.we    = 1'b1;
                  list_port.waddr = shift_idx[PAGE_W-1:0];
                  list_port.wdata = list_rdata;
               end else if (list_rdata == page_ff) begin
                  found_in = 1'b1;
               end
            end
            lpg_vld_in = (rd_idx_ff < len_ff);
            if (rd_idx_ff < len_ff) begin
               list_port.re    = 1'b1;
               list_port.raddr = rd_idx_ff[PAGE_W-1:0];
               rd_idx_in       = rd_idx_ff + LEN_W'(1);
            end
            if (list_done && found_ff) len_in = len_ff - LEN_W'(1);
         end

         ST_DONE: begin
            if (res_load) begin
               rsp_in     = res_ff;
               rsp_vld_in = 1'b1;
            end
         end

         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         lpg_vld_ff  <= 1'b0;
         mchk_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         len_ff      <= LEN_W'(1);
         active_ff   <= PAGE_NUM'(1);
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         lpg_vld_ff  <= lpg_vld_in;
         mchk_vld_ff <= mchk_vld_in;
         found_ff    <= found_in;
         len_ff      <= len_in;
         active_ff   <= active_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      slot_ff   <= slot_in;
      rd_idx_ff <= rd_idx_in;
      mpg_ff    <= mpg_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // the length drops only once the list has closed up behind a released page
   `BSSA_ASSERT(a_len_matches_active, clock, reset, state_ff != ST_FREE_LIST, $countones(active_ff) == int'(len_ff), "list length differs from active page count")
   `BSSA_ASSERT(a_head_active, clock, reset, 1'b1, active_ff[HEAD_PAGE], "head page went inactive")
   `BSSA_ASSERT(a_list_shift_apart, clock, reset, list_port.we && list_port.re, list_port.waddr != list_port.raddr, "list shift writes the entry being read")
   `BSSA_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_vld_ff), $past(state_ff == ST_DONE), "response loaded outside done state")
   `BSSA_ASSERT_NEXT(a_release_clears, clock, reset, state_ff == ST_FREE_MASK && state_in == ST_FREE_LIST, !active_ff[page_ff], "released page still active")

endmodule

[rtl/bitmap_slab_slot_allocator.sv]
// Top level of the bitmap slab slot allocator: size register, memories and sequencer
//
//   channel   | ports                          | direction | moves
//   ----------+--------------------------------+-----------+------------------------------
//   request   | req_valid req_ready req_data   | in        | allocate or free transaction
//   response  | rsp_valid rsp_ready rsp_data   | out       | one result per transaction
//   csr       | csr_we csr_wdata               | in        | object size, no wait
//
// Allocate: the list is walked, one list entry a cycle, and the first page with room
// gets a slot; when none has, the lowest inactive page is appended, up to 16 pages.
// Free: clears the slot; an emptied non-head page is released and the list closed up.
// One transaction at a time; a new request is taken while the previous response waits.
// Reset is synchronous; memory valid bits clear at once, so there is no clearing pass.
// A stalled response holds the block in its done state once a second result is ready.
module bitmap_slab_slot_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bssa_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bssa_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [bssa_pkg::SIZE_W-1:0]   csr_wdata
);
   import bssa_pkg::*;

   logic [SHIFT_W-1:0] shift_ff, shift_in;
   mask_port_type      mask_port;
   list_port_type      list_port;
   logic [SLOTS-1:0]   mask_rdata;
   logic [PAGE_W-1:0]  list_rdata;

   // object size kept as its slot shift
   assign shift_in = csr_we ? size_shift(csr_wdata) : shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= size_shift(SIZE_W'(1));
      end else begin
         shift_ff <= shift_in;
      end
   end

   // held-slot bitmaps, one word per page
   bssa_ram #(
      .DATA_W (SLOTS),
      .DEPTH  (PAGE_NUM)
   ) u_mask_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mask_port.re),
      .rd_addr (mask_port.raddr),
      .rd_data (mask_rdata),
      .wr_en   (mask_port.we),
      .wr_addr (mask_port.waddr),
      .wr_data (mask_port.wdata)
   );

   // active page list in walk order
   bssa_ram #(
      .DATA_W (PAGE_W),
      .DEPTH  (PAGE_NUM)
   ) u_list_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (list_port.re),
      .rd_addr (list_port.raddr),
      .rd_data (list_rdata),
      .wr_en   (list_port.we),
      .wr_addr (list_port.waddr),
      .wr_data (list_port.wdata)
   );

   bssa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .shift      (shift_ff),
      .mask_port  (mask_port),
      .mask_rdata (mask_rdata),
      .list_port  (list_port),
      .list_rdata (list_rdata)
   );

endmodule
